FILE: rtl/sadf_pkg.sv
// Package for the sensor advertising frame filter.
// Shared types and fixed constants; no dependencies.
package sadf_pkg;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_TYPE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SIGNATURE  = 1'b1;

	localparam logic [7:0]  TYPE_RESET = 8'hFF;
	localparam logic [15:0] SIG_RESET  = 16'hAA55;
	localparam logic [7:0]  CRC_INIT   = 8'hFF;
	localparam logic [7:0]  CRC_POLY   = 8'h31;
	localparam logic [5:0]  COUNT_MAX  = 6'd63;

	// One finished frame handed from the front part to the emitter.
	typedef struct packed {
		logic [7:0] crc;
		logic       bank;
	} job_t;

endpackage

FILE: rtl/sensor_advert_frame_filter.sv
// Top level of the sensor advertising frame filter.
// Instantiates sadf_front, sadf_back and sadf_ram; uses sadf_pkg.

// The filter takes an advertising record one byte per transaction on the
// slave stream, with tlast on the final byte and tuser set when the record came
// as a non-connectable event. A record is a sensor frame when it is exactly
// 2 + 10 + 2*PM_COUNT bytes long, its length byte is one more than the payload
// length, its type byte equals the frame_type register and its first payload
// word (little-endian) equals the signature register. CRC-8 (polynomial 0x31,
// start 0xFF, MSB first) runs over the payload. A frame whose CRC differs from
// the last reported one is sent out as 4 + PM_COUNT transactions on the master
// stream, one per measurement word, each carrying the frame CRC, with tlast on
// the final word; a repeated CRC, or a record without tuser, sends nothing.
// Record bytes are taken at one per cycle. The final byte of a record is held
// off only while the emitter is still sending the previous frame, because the
// emitter owns the reported CRC and one of the two word banks until it is done.
// The emitter reads the word RAM through its registered port, fetching each
// word in its FETCH state and loading it into the output register in its LOAD
// state, and it is free again from the cycle in which the final word is offered.
// Configuration writes are taken in any cycle and should be made while the
// block is idle.
module sensor_advert_frame_filter import sadf_pkg::*; #(
	parameter int PM_COUNT = 9
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration: index 0 frame_type, index 1 signature.
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [7:0] data_byte
	input  logic                  s_tlast,   // record_last
	input  logic                  s_tuser,   // nonconn_event
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [31:0]           m_tdata,   // [3:0] field_index, [19:4] field_value,
	                                         // [27:20] frame_crc, [31:28] zero
	output logic                  m_tlast    // last_of_frame
);

	localparam int WORDS = 4 + PM_COUNT;
	localparam int DEPTH = 2 * WORDS;
	localparam int AW    = $clog2(DEPTH);

	logic          push;
	logic          busy;
	job_t          job;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [15:0]   ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [15:0]   ram_rdata;
	logic [3:0]    field_index;
	logic [15:0]   field_value;
	logic [7:0]    frame_crc;

	sadf_front #(.PM_COUNT(PM_COUNT), .AW(AW)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_byte    (s_tdata),
		.in_last    (s_tlast),
		.in_nonconn (s_tuser),
		.busy       (busy),
		.push       (push),
		.job        (job),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata)
	);

	// Two banks of measurement words: the front fills one while the
	// emitter reads the other.
	sadf_ram #(.WIDTH(16), .DEPTH(DEPTH), .AW(AW)) u_words (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	sadf_back #(.PM_COUNT(PM_COUNT), .AW(AW)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.job       (job),
		.busy      (busy),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_index (field_index),
		.out_value (field_value),
		.out_crc   (frame_crc),
		.out_last  (m_tlast)
	);

	assign m_tdata = {4'd0, frame_crc, field_value, field_index};

`ifndef SYNTHESIS
	// A new frame is never handed over while the emitter still owns one.
	assert property (@(posedge clk) disable iff (!arst_n) push |-> !busy)
		else $error("frame handed to emitter while busy");

	// A handed-over frame keeps the emitter busy in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n) push |=> busy)
		else $error("emitter lost a frame");

	// Only the final byte of a record is ever held off.
	assert property (@(posedge clk) disable iff (!arst_n) !s_tready |-> s_tlast)
		else $error("non-final record byte stalled");

	// The word that closes a frame is always the last measurement word.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (m_tdata[3:0] == 4'(WORDS - 1)))
		else $error("frame closed on wrong word");
`endif

endmodule

FILE: rtl/sadf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sadf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 26,
	parameter int AW    = 5
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/sadf_front.sv
// Front part of the frame filter: takes record bytes, checks the frame,
// runs the CRC and writes measurement words into the word RAM. Uses sadf_pkg.
module sadf_front import sadf_pkg::*; #(
	parameter int PM_COUNT = 9,
	parameter int AW       = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            in_byte,
	input  logic                  in_last,
	input  logic                  in_nonconn,
	input  logic                  busy,
	output logic                  push,
	output job_t                  job,
	output logic                  ram_we,
	output logic [AW-1:0]         ram_waddr,
	output logic [15:0]           ram_wdata
);

	localparam int WORDS   = 4 + PM_COUNT;
	localparam int PAY_LEN = 10 + 2 * PM_COUNT;
	localparam int REC_LEN = PAY_LEN + 2;
	localparam int IW      = $clog2(WORDS);

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

	logic [7:0]  frame_type_q;
	logic [15:0] signature_q;
	logic [5:0]  byte_count_q;
	logic [7:0]  running_crc_q;
	logic        record_ok_q;
	logic [7:0]  low_byte_q;
	logic [7:0]  reported_crc_q;
	logic        bank_q;

	logic [5:0]    count_nx;
	logic [7:0]    crc_nx;
	logic          ok_nx;
	logic [7:0]    low_nx;
	logic          word_we;
	logic [IW-1:0] word_idx;
	logic [5:0]    off;
	logic [4:0]    word_no;
	logic          take;
	logic          emit;

	always_comb begin
		ok_nx    = record_ok_q;
		crc_nx   = running_crc_q;
		low_nx   = low_byte_q;
		word_we  = 1'b0;
		word_idx = '0;
		off      = byte_count_q - 6'd2;
		word_no  = off[5:1];
		if (byte_count_q == 6'd0) begin
			if (in_byte != 8'(PAY_LEN + 1)) ok_nx = 1'b0;
		end else if (byte_count_q == 6'd1) begin
			if (in_byte != frame_type_q) ok_nx = 1'b0;
		end else if (byte_count_q < 6'(REC_LEN)) begin
			crc_nx = crc8_byte(running_crc_q, in_byte);
			if (!off[0]) begin
				low_nx = in_byte;
			end else if (word_no == 5'd0) begin
				if ({in_byte, low_byte_q} != signature_q) ok_nx = 1'b0;
			end else if (word_no <= 5'(WORDS)) begin
				word_we  = 1'b1;
				word_idx = IW'(word_no - 5'd1);
			end
		end else begin
			ok_nx = 1'b0;
		end
		count_nx = (byte_count_q == COUNT_MAX) ? COUNT_MAX : byte_count_q + 6'd1;
	end

	// A final byte waits while the emitter still owns a frame, so the
	// reported CRC and the bank swap stay in step with emission.
	assign in_ready = !(in_last && busy);
	assign take     = in_valid && in_ready;
	assign emit     = in_last && ok_nx && in_nonconn && (count_nx == 6'(REC_LEN))
		&& (crc_nx != reported_crc_q);
	assign push     = take && emit;

	assign job.crc   = crc_nx;
	assign job.bank  = bank_q;
	assign ram_we    = take && word_we;
	assign ram_waddr = bank_q ? AW'(WORDS) + AW'(word_idx) : AW'(word_idx);
	assign ram_wdata = {in_byte, low_byte_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_type_q   <= TYPE_RESET;
			signature_q    <= SIG_RESET;
			byte_count_q   <= '0;
			running_crc_q  <= CRC_INIT;
			record_ok_q    <= 1'b1;
			low_byte_q     <= '0;
			reported_crc_q <= CRC_INIT;
			bank_q         <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_FRAME_TYPE) frame_type_q <= cfg_wdata[7:0];
				if (cfg_index == REG_SIGNATURE)  signature_q  <= cfg_wdata;
			end
			if (take) begin
				if (in_last) begin
					byte_count_q  <= '0;
					running_crc_q <= CRC_INIT;
					record_ok_q   <= 1'b1;
					low_byte_q    <= '0;
				end else begin
					byte_count_q  <= count_nx;
					running_crc_q <= crc_nx;
					record_ok_q   <= ok_nx;
					low_byte_q    <= low_nx;
				end
			end
			if (push) begin
				reported_crc_q <= crc_nx;
				bank_q         <= !bank_q;
			end
		end
	end

endmodule

FILE: rtl/sadf_back.sv
// Back part of the frame filter: a one-entry job queue and the emitter that
// reads the stored words of a frame and sends them out. Uses sadf_pkg.
module sadf_back import sadf_pkg::*; #(
	parameter int PM_COUNT = 9,
	parameter int AW       = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  job_t          job,
	output logic          busy,
	output logic [AW-1:0] ram_raddr,
	input  logic [15:0]   ram_rdata,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [3:0]    out_index,
	output logic [15:0]   out_value,
	output logic [7:0]    out_crc,
	output logic          out_last
);

	localparam int WORDS = 4 + PM_COUNT;
	localparam int IW    = $clog2(WORDS);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_FETCH = 2'd1;
	localparam logic [1:0] S_LOAD  = 2'd2;

	logic          job_valid_q;
	job_t          job_q;
	job_t          active_q;
	logic [1:0]    state_q;
	logic [IW-1:0] idx_q;
	logic          out_valid_q;
	logic [3:0]    out_index_q;
	logic [15:0]   out_value_q;
	logic [7:0]    out_crc_q;
	logic          out_last_q;
	logic          out_free;
	logic          is_last_word;

	assign busy         = job_valid_q || (state_q != S_IDLE);
	assign ram_raddr    = active_q.bank ? AW'(WORDS) + AW'(idx_q) : AW'(idx_q);
	assign out_free     = !out_valid_q || out_ready;
	assign is_last_word = (idx_q == IW'(WORDS - 1));

	assign out_valid = out_valid_q;
	assign out_index = out_index_q;
	assign out_value = out_value_q;
	assign out_crc   = out_crc_q;
	assign out_last  = out_last_q;

	always_ff @(posedge clk) begin
		if (push) job_q <= job;
		if (state_q == S_IDLE && job_valid_q) active_q <= job_q;
		if (state_q == S_LOAD && out_free) begin
			out_index_q <= 4'(idx_q);
			out_value_q <= ram_rdata;
			out_crc_q   <= active_q.crc;
			out_last_q  <= is_last_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			state_q     <= S_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A push only happens while the emitter is idle with no job queued.
			if (push) begin
				job_valid_q <= 1'b1;
			end else if (state_q == S_IDLE) begin
				job_valid_q <= 1'b0;
			end
			if (state_q == S_LOAD && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (job_valid_q) begin
						idx_q   <= '0;
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					if (out_free) begin
						if (is_last_word) begin
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_q + IW'(1);
							state_q <= S_FETCH;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
